FILE: rtl/bcpu_pkg.sv
package bcpu_pkg;

  localparam int KindW    = 6;
  localparam int ByteW    = 8;
  localparam int CondW    = 3;
  localparam int PcW      = 16;
  localparam int InDataW  = 40;
  localparam int OutDataW = 40;

  localparam int QueueDepthDefault = 4;

  // Operation codes match the kind field one for one; unknown kinds map to OP_NOP.
  typedef enum logic [KindW-1:0] {
    OP_ADC = 6'd0,  OP_SBC = 6'd1,  OP_AND = 6'd2,  OP_ORA = 6'd3,
    OP_EOR = 6'd4,  OP_CMP = 6'd5,  OP_CPX = 6'd6,  OP_CPY = 6'd7,
    OP_BIT = 6'd8,  OP_ASL = 6'd9,  OP_ROL = 6'd10, OP_ROR = 6'd11,
    OP_INC = 6'd12, OP_DEC = 6'd13, OP_LDA = 6'd14, OP_LDX = 6'd15,
    OP_LDY = 6'd16, OP_STA = 6'd17, OP_STX = 6'd18, OP_STY = 6'd19,
    OP_TAX = 6'd20, OP_TAY = 6'd21, OP_TXA = 6'd22, OP_TYA = 6'd23,
    OP_TSX = 6'd24, OP_TXS = 6'd25, OP_INX = 6'd26, OP_INY = 6'd27,
    OP_DEX = 6'd28, OP_DEY = 6'd29, OP_CLC = 6'd30, OP_SEC = 6'd31,
    OP_CLI = 6'd32, OP_SEI = 6'd33, OP_CLD = 6'd34, OP_SED = 6'd35,
    OP_CLV = 6'd36, OP_BRANCH = 6'd37, OP_NOP = 6'd38
  } op_t;

  // Flag selected by branch_condition[2:1]
  typedef enum logic [1:0] {
    BR_N = 2'd0,
    BR_V = 2'd1,
    BR_C = 2'd2,
    BR_Z = 2'd3
  } br_flag_t;

  localparam logic [ByteW-1:0] SpReset = 8'hFF;

  typedef struct packed {
    op_t              op;
    logic [ByteW-1:0] operand;
    logic             to_accumulator;
    logic [CondW-1:0] branch_condition;
    logic [PcW-1:0]   pc;
  } item_t;

  typedef struct packed {
    logic [ByteW-1:0] result_byte;
    logic             write_memory;
    logic [ByteW-1:0] status_flags;
    logic             branch_taken;
    logic [PcW-1:0]   next_pc;
  } result_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

FILE: rtl/bcpu_front.sv
module bcpu_front (
  input  logic [bcpu_pkg::InDataW-1:0] in_data,
  output bcpu_pkg::item_t              item
);
  import bcpu_pkg::*;

  logic [KindW-1:0] kind;

  assign kind = in_data[5:0];

  always_comb begin
    item.operand          = in_data[13:6];
    item.to_accumulator   = in_data[14];
    item.branch_condition = in_data[17:15];
    item.pc               = in_data[33:18];
    // fold undefined kinds into NOP
    if (kind <= OP_NOP) begin
      item.op = op_t'(kind);
    end else begin
      item.op = OP_NOP;
    end
  end

endmodule

FILE: rtl/bcpu_queue.sv
module bcpu_queue #(
  parameter int Depth = bcpu_pkg::QueueDepthDefault
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  bcpu_pkg::item_t         push_item,
  input  logic                    pop,
  output bcpu_pkg::item_t         head_item,
  output bcpu_pkg::queue_status_t status
);
  import bcpu_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           entry_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == FullCnt);
  assign head_item    = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: rtl/bcpu_back.sv
module bcpu_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_valid,
  input  bcpu_pkg::item_t item,
  output logic            item_pop,
  output logic            res_valid,
  input  logic            res_ready,
  output bcpu_pkg::result_t res
);
  import bcpu_pkg::*;

  logic [ByteW-1:0] a_r, a_nxt, x_r, x_nxt, y_r, y_nxt, sp_r, sp_nxt;
  logic c_r, c_nxt, z_r, z_nxt, i_r, i_nxt, d_r, d_nxt, v_r, v_nxt, n_r, n_nxt;
  logic    out_valid_r;
  result_t out_r, out_nxt;

  logic [ByteW-1:0] m, add_m, add_res, mod_src, mod_res, nz_val, cmp_reg;
  logic [ByteW:0]   sum, diff;
  logic             mod_c, nz_upd, br_flag, br_hold;
  logic [PcW-1:0]   offset;

  assign item_pop  = item_valid && (!out_valid_r || res_ready);
  assign res_valid = out_valid_r;
  assign res       = out_r;

  assign m       = item.operand;
  assign add_m   = (item.op == OP_SBC) ? ~m : m;
  assign sum     = {1'b0, a_r} + {1'b0, add_m} + {{ByteW{1'b0}}, c_r};
  assign add_res = sum[ByteW-1:0];
  assign diff    = {1'b0, cmp_reg} - {1'b0, m};
  assign mod_src = item.to_accumulator ? a_r : m;
  assign offset  = {{(PcW-ByteW){m[ByteW-1]}}, m};

  always_comb begin
    case (item.op)
      OP_CPX:  cmp_reg = x_r;
      OP_CPY:  cmp_reg = y_r;
      default: cmp_reg = a_r;
    endcase
  end

  always_comb begin
    mod_c = c_r;
    case (item.op)
      OP_ASL: begin
        mod_res = {mod_src[ByteW-2:0], 1'b0};
        mod_c   = mod_src[ByteW-1];
      end
      OP_ROL: begin
        mod_res = {mod_src[ByteW-2:0], c_r};
        mod_c   = mod_src[ByteW-1];
      end
      OP_ROR: begin
        mod_res = {c_r, mod_src[ByteW-1:1]};
        mod_c   = mod_src[0];
      end
      OP_INC:  mod_res = mod_src + 1'b1;
      default: mod_res = mod_src - 1'b1;
    endcase
  end

  always_comb begin
    case (br_flag_t'(item.branch_condition[2:1]))
      BR_N:    br_flag = n_r;
      BR_V:    br_flag = v_r;
      BR_C:    br_flag = c_r;
      default: br_flag = z_r;
    endcase
    br_hold = item.branch_condition[0] ? br_flag : !br_flag;
  end

  always_comb begin
    a_nxt  = a_r;
    x_nxt  = x_r;
    y_nxt  = y_r;
    sp_nxt = sp_r;
    c_nxt  = c_r;
    i_nxt  = i_r;
    d_nxt  = d_r;
    v_nxt  = v_r;
    nz_upd = 1'b0;
    nz_val = '0;
    z_nxt  = z_r;
    n_nxt  = n_r;
    out_nxt.result_byte  = '0;
    out_nxt.write_memory = 1'b0;
    out_nxt.branch_taken = 1'b0;
    out_nxt.next_pc      = item.pc;
    case (item.op)
      OP_ADC, OP_SBC: begin
        a_nxt  = add_res;
        c_nxt  = sum[ByteW];
        v_nxt  = ~(a_r[ByteW-1] ^ add_m[ByteW-1]) & (a_r[ByteW-1] ^ add_res[ByteW-1]);
        nz_upd = 1'b1;
        nz_val = add_res;
      end
      OP_AND: begin
        a_nxt = a_r & m; nz_upd = 1'b1; nz_val = a_r & m;
      end
      OP_ORA: begin
        a_nxt = a_r | m; nz_upd = 1'b1; nz_val = a_r | m;
      end
      OP_EOR: begin
        a_nxt = a_r ^ m; nz_upd = 1'b1; nz_val = a_r ^ m;
      end
      OP_CMP, OP_CPX, OP_CPY: begin
        c_nxt  = !diff[ByteW];
        nz_upd = 1'b1;
        nz_val = diff[ByteW-1:0];
      end
      OP_BIT: begin
        n_nxt = m[7];
        v_nxt = m[6];
        z_nxt = ((a_r & m) == '0);
      end
      OP_ASL, OP_ROL, OP_ROR, OP_INC, OP_DEC: begin
        c_nxt  = mod_c;
        nz_upd = 1'b1;
        nz_val = mod_res;
        if (item.to_accumulator) begin
          a_nxt = mod_res;
        end else begin
          out_nxt.result_byte  = mod_res;
          out_nxt.write_memory = 1'b1;
        end
      end
      OP_LDA: begin
        a_nxt = m; nz_upd = 1'b1; nz_val = m;
      end
      OP_LDX: begin
        x_nxt = m; nz_upd = 1'b1; nz_val = m;
      end
      OP_LDY: begin
        y_nxt = m; nz_upd = 1'b1; nz_val = m;
      end
      OP_STA: begin
        out_nxt.result_byte = a_r; out_nxt.write_memory = 1'b1;
      end
      OP_STX: begin
        out_nxt.result_byte = x_r; out_nxt.write_memory = 1'b1;
      end
      OP_STY: begin
        out_nxt.result_byte = y_r; out_nxt.write_memory = 1'b1;
      end
      OP_TAX: begin
        x_nxt = a_r; nz_upd = 1'b1; nz_val = a_r;
      end
      OP_TAY: begin
        y_nxt = a_r; nz_upd = 1'b1; nz_val = a_r;
      end
      OP_TXA: begin
        a_nxt = x_r; nz_upd = 1'b1; nz_val = x_r;
      end
      OP_TYA: begin
        a_nxt = y_r; nz_upd = 1'b1; nz_val = y_r;
      end
      OP_TSX: begin
        x_nxt = sp_r; nz_upd = 1'b1; nz_val = sp_r;
      end
      OP_TXS: sp_nxt = x_r;
      OP_INX: begin
        x_nxt = x_r + 1'b1; nz_upd = 1'b1; nz_val = x_r + 1'b1;
      end
      OP_INY: begin
        y_nxt = y_r + 1'b1; nz_upd = 1'b1; nz_val = y_r + 1'b1;
      end
      OP_DEX: begin
        x_nxt = x_r - 1'b1; nz_upd = 1'b1; nz_val = x_r - 1'b1;
      end
      OP_DEY: begin
        y_nxt = y_r - 1'b1; nz_upd = 1'b1; nz_val = y_r - 1'b1;
      end
      OP_CLC: c_nxt = 1'b0;
      OP_SEC: c_nxt = 1'b1;
      OP_CLI: i_nxt = 1'b0;
      OP_SEI: i_nxt = 1'b1;
      OP_CLD: d_nxt = 1'b0;
      OP_SED: d_nxt = 1'b1;
      OP_CLV: v_nxt = 1'b0;
      OP_BRANCH: begin
        if (br_hold) begin
          out_nxt.branch_taken = 1'b1;
          out_nxt.next_pc      = item.pc + offset;
        end
      end
      default: ;
    endcase
    if (nz_upd) begin
      n_nxt = nz_val[ByteW-1];
      z_nxt = (nz_val == '0);
    end
    // bit 5 reads one, break bit reads zero
    out_nxt.status_flags = {n_nxt, v_nxt, 1'b1, 1'b0, d_nxt, i_nxt, z_nxt, c_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r         <= '0;
      x_r         <= '0;
      y_r         <= '0;
      sp_r        <= SpReset;
      c_r         <= 1'b0;
      z_r         <= 1'b0;
      i_r         <= 1'b1;
      d_r         <= 1'b0;
      v_r         <= 1'b0;
      n_r         <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (item_pop) begin
        a_r  <= a_nxt;
        x_r  <= x_nxt;
        y_r  <= y_nxt;
        sp_r <= sp_nxt;
        c_r  <= c_nxt;
        z_r  <= z_nxt;
        i_r  <= i_nxt;
        d_r  <= d_nxt;
        v_r  <= v_nxt;
        n_r  <= n_nxt;
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      out_r <= out_nxt;
    end
  end

endmodule

FILE: rtl/byte_cpu_execute_unit.sv
// Execute stage of a 6502-style 8-bit CPU: one decoded instruction per input word, one
// result word per instruction, sustained at one word per clock while the output is not
// stalled. An accepted word waits in a QueueDepth-entry queue; the execute stage takes
// the queue head when its output register is free or being emptied, updates A, X, Y, SP
// and the flags, and registers the result, so out_tvalid rises in the cycle after its
// instruction is taken. The queue and the single output register absorb output
// stalls; in_tready drops only when the queue is full.
module byte_cpu_execute_unit #(
  parameter int QueueDepth = bcpu_pkg::QueueDepthDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // kind[5:0], operand[13:6], to_accumulator[14], branch_condition[17:15], pc[33:18]
  input  logic [bcpu_pkg::InDataW-1:0]  in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // result_byte[7:0], write_memory[8], status_flags[16:9], branch_taken[17],
  // next_pc[33:18]
  output logic [bcpu_pkg::OutDataW-1:0] out_tdata
);
  import bcpu_pkg::*;

  item_t         in_item, head_item;
  queue_status_t q_status;
  logic          push, pop;
  result_t       res;

  assign in_tready = !q_status.full;
  assign push      = in_tvalid && in_tready;

  bcpu_front u_front (
    .in_data (in_tdata),
    .item    (in_item)
  );

  bcpu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (in_item),
    .pop       (pop),
    .head_item (head_item),
    .status    (q_status)
  );

  bcpu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (!q_status.empty),
    .item       (head_item),
    .item_pop   (pop),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  assign out_tdata = {6'b0, res.next_pc, res.branch_taken, res.status_flags,
                      res.write_memory, res.result_byte};

  // no write-back byte without a memory write
  a_wb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[8] |-> out_tdata[7:0] == 8'h00)
    else $error("result_byte nonzero without write_memory");

  // fixed status bits
  a_status_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[14] && !out_tdata[13])
    else $error("status byte fixed bits wrong");

  a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_status.full && q_status.empty))
    else $error("queue both full and empty");

  // an item popped from the queue always shows up as a result next cycle
  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_tvalid)
    else $error("popped item produced no result");

endmodule

FILE: bench/tb_byte_cpu_execute_unit.sv
`timescale 1ns / 1ps

module tb_byte_cpu_execute_unit;
  import bcpu_pkg::*;

  localparam int TotalWords   = 1850;
  localparam int DirectedRows = 45;
  localparam int RandomWords  = TotalWords - DirectedRows;
  localparam int MaxReports   = 10;
  localparam int MaxGap       = 11;

  localparam logic [KindW-1:0] KindTop = 6'd63;

  localparam logic [CondW-1:0] CondBpl = 3'd0;
  localparam logic [CondW-1:0] CondBmi = 3'd1;
  localparam logic [CondW-1:0] CondBvc = 3'd2;
  localparam logic [CondW-1:0] CondBvs = 3'd3;
  localparam logic [CondW-1:0] CondBcc = 3'd4;
  localparam logic [CondW-1:0] CondBcs = 3'd5;
  localparam logic [CondW-1:0] CondBne = 3'd6;
  localparam logic [CondW-1:0] CondBeq = 3'd7;

  localparam logic [ByteW-1:0] BoundaryBytes [5] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] operand;
    logic             to_acc;
    logic [CondW-1:0] cond;
    logic [PcW-1:0]   pc;
  } instr_t;

  typedef struct {
    instr_t  insn;
    logic    typed;
    result_t want;
  } directed_row_t;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;

  // Predicted CPU state
  logic [ByteW-1:0] cpu_a, cpu_x, cpu_y, cpu_sp;
  logic             flag_c, flag_z, flag_i, flag_d, flag_v, flag_n;

  result_t pending_results [$];
  int      error_count = 0;
  logic    quiet_in    = 1'b0;
  logic    quiet_out   = 1'b0;

  // Directed words: typed expectations on the first rows, the predictor on the rest
  directed_row_t directed_rows [DirectedRows] = '{
    '{'{OP_NOP, 8'h00, 1'b0, CondBpl, 16'h0000}, 1'b1, '{8'h00, 1'b0, 8'h24, 1'b0, 16'h0000}},
    '{'{KindTop, 8'hFF, 1'b1, CondBeq, 16'hFFFF}, 1'b1, '{8'h00, 1'b0, 8'h24, 1'b0, 16'hFFFF}},
    '{'{OP_LDA, 8'h80, 1'b0, CondBpl, 16'h1234}, 1'b1, '{8'h00, 1'b0, 8'hA4, 1'b0, 16'h1234}},
    '{'{OP_ADC, 8'h80, 1'b0, CondBpl, 16'h0001}, 1'b1, '{8'h00, 1'b0, 8'h67, 1'b0, 16'h0001}},
    '{'{OP_BRANCH, 8'h80, 1'b0, CondBeq, 16'h0000}, 1'b1,
      '{8'h00, 1'b0, 8'h67, 1'b1, 16'hFF80}},
    '{'{OP_BRANCH, 8'h7F, 1'b0, CondBne, 16'hFFFF}, 1'b1,
      '{8'h00, 1'b0, 8'h67, 1'b0, 16'hFFFF}},
    '{'{OP_BRANCH, 8'h7F, 1'b0, CondBcs, 16'hFFF0}, 1'b1,
      '{8'h00, 1'b0, 8'h67, 1'b1, 16'h006F}},
    '{'{OP_SBC, 8'h01, 1'b0, CondBpl, 16'h0002}, 1'b0, '{default: '0}},
    '{'{OP_LDA, 8'h7F, 1'b0, CondBpl, 16'h0003}, 1'b0, '{default: '0}},
    '{'{OP_ADC, 8'h01, 1'b0, CondBpl, 16'h0004}, 1'b0, '{default: '0}},
    '{'{OP_SBC, 8'hFF, 1'b0, CondBpl, 16'h0005}, 1'b0, '{default: '0}},
    '{'{OP_AND, 8'hFF, 1'b0, CondBpl, 16'h0006}, 1'b0, '{default: '0}},
    '{'{OP_ORA, 8'h00, 1'b0, CondBpl, 16'h0007}, 1'b0, '{default: '0}},
    '{'{OP_EOR, 8'hFF, 1'b0, CondBpl, 16'h0008}, 1'b0, '{default: '0}},
    '{'{OP_CMP, 8'h00, 1'b0, CondBpl, 16'h0009}, 1'b0, '{default: '0}},
    '{'{OP_CPX, 8'hFF, 1'b0, CondBpl, 16'h000A}, 1'b0, '{default: '0}},
    '{'{OP_CPY, 8'h80, 1'b0, CondBpl, 16'h000B}, 1'b0, '{default: '0}},
    '{'{OP_BIT, 8'hC0, 1'b0, CondBpl, 16'h000C}, 1'b0, '{default: '0}},
    '{'{OP_ASL, 8'h55, 1'b1, CondBpl, 16'h000D}, 1'b0, '{default: '0}},
    '{'{OP_ROL, 8'h80, 1'b0, CondBpl, 16'h000E}, 1'b0, '{default: '0}},
    '{'{OP_ROR, 8'h01, 1'b0, CondBpl, 16'h000F}, 1'b0, '{default: '0}},
    '{'{OP_ROR, 8'h00, 1'b1, CondBpl, 16'h0010}, 1'b0, '{default: '0}},
    '{'{OP_INC, 8'h00, 1'b1, CondBpl, 16'h0011}, 1'b0, '{default: '0}},
    '{'{OP_DEC, 8'h00, 1'b0, CondBpl, 16'h0012}, 1'b0, '{default: '0}},
    '{'{OP_INC, 8'hFF, 1'b0, CondBpl, 16'h0013}, 1'b0, '{default: '0}},
    '{'{OP_DEC, 8'h00, 1'b1, CondBpl, 16'h0014}, 1'b0, '{default: '0}},
    '{'{OP_LDX, 8'h80, 1'b0, CondBpl, 16'h0015}, 1'b0, '{default: '0}},
    '{'{OP_LDY, 8'hFF, 1'b0, CondBpl, 16'h0016}, 1'b0, '{default: '0}},
    '{'{OP_STA, 8'h00, 1'b0, CondBpl, 16'h0017}, 1'b0, '{default: '0}},
    '{'{OP_STX, 8'h00, 1'b0, CondBpl, 16'h0018}, 1'b0, '{default: '0}},
    '{'{OP_STY, 8'h00, 1'b0, CondBpl, 16'h0019}, 1'b0, '{default: '0}},
    '{'{OP_TSX, 8'h00, 1'b0, CondBpl, 16'h001A}, 1'b0, '{default: '0}},
    '{'{OP_TAX, 8'h00, 1'b0, CondBpl, 16'h001B}, 1'b0, '{default: '0}},
    '{'{OP_TAY, 8'h00, 1'b0, CondBpl, 16'h001C}, 1'b0, '{default: '0}},
    '{'{OP_INX, 8'h00, 1'b0, CondBpl, 16'h001D}, 1'b0, '{default: '0}},
    '{'{OP_TXS, 8'h00, 1'b0, CondBpl, 16'h001E}, 1'b0, '{default: '0}},
    '{'{OP_DEY, 8'h00, 1'b0, CondBpl, 16'h001F}, 1'b0, '{default: '0}},
    '{'{OP_TXA, 8'h00, 1'b0, CondBpl, 16'h0020}, 1'b0, '{default: '0}},
    '{'{OP_TYA, 8'h00, 1'b0, CondBpl, 16'h0021}, 1'b0, '{default: '0}},
    '{'{OP_INY, 8'h00, 1'b0, CondBpl, 16'h0022}, 1'b0, '{default: '0}},
    '{'{OP_DEX, 8'h00, 1'b0, CondBmi, 16'h0023}, 1'b0, '{default: '0}},
    '{'{OP_SEC, 8'h00, 1'b0, CondBpl, 16'h0024}, 1'b0, '{default: '0}},
    '{'{OP_SED, 8'h00, 1'b0, CondBvs, 16'h0025}, 1'b0, '{default: '0}},
    '{'{OP_CLI, 8'h00, 1'b0, CondBvc, 16'h0026}, 1'b0, '{default: '0}},
    '{'{OP_BRANCH, 8'hFE, 1'b0, CondBcc, 16'h0001}, 1'b0, '{default: '0}}
  };

  byte_cpu_execute_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_byte_cpu_execute_unit: errors");
    $finish;
  end

  function automatic logic [ByteW-1:0] set_nz(input logic [ByteW-1:0] v);
    flag_n = v[7];
    flag_z = (v == 8'h00);
    return v;
  endfunction

  function automatic logic [ByteW-1:0] add_with_carry(input logic [ByteW-1:0] a,
                                                      input logic [ByteW-1:0] m);
    logic [ByteW:0]   sum;
    logic [ByteW-1:0] r;
    sum    = {1'b0, a} + {1'b0, m} + {8'h00, flag_c};
    r      = sum[ByteW-1:0];
    flag_c = sum[ByteW];
    flag_v = ~(a[7] ^ m[7]) & (a[7] ^ r[7]);
    return set_nz(r);
  endfunction

  function automatic void compare_reg(input logic [ByteW-1:0] r, input logic [ByteW-1:0] m);
    logic [ByteW-1:0] diff;
    diff   = r - m;
    flag_c = (r >= m);
    void'(set_nz(diff));
  endfunction

  function automatic logic [ByteW-1:0] shift_or_step(input logic [KindW-1:0] kind,
                                                     input logic [ByteW-1:0] v);
    logic             cin;
    logic [ByteW-1:0] r;
    cin = flag_c;
    case (kind)
      OP_ASL: begin
        flag_c = v[7];
        r = {v[6:0], 1'b0};
      end
      OP_ROL: begin
        flag_c = v[7];
        r = {v[6:0], cin};
      end
      OP_ROR: begin
        flag_c = v[0];
        r = {cin, v[7:1]};
      end
      OP_INC: r = v + 8'h01;
      default: r = v - 8'h01;
    endcase
    return set_nz(r);
  endfunction

  function automatic logic branch_holds(input logic [CondW-1:0] cond);
    logic f;
    case (br_flag_t'(cond[2:1]))
      BR_N: f = flag_n;
      BR_V: f = flag_v;
      BR_C: f = flag_c;
      default: f = flag_z;
    endcase
    return cond[0] ? f : ~f;
  endfunction

  // Advance the predicted CPU by one instruction and return what the unit should emit
  function automatic result_t execute_instr(input instr_t w);
    result_t r;
    r = '0;
    r.next_pc = w.pc;
    case (w.kind)
      OP_ADC: cpu_a = add_with_carry(cpu_a, w.operand);
      OP_SBC: cpu_a = add_with_carry(cpu_a, ~w.operand);
      OP_AND: cpu_a = set_nz(cpu_a & w.operand);
      OP_ORA: cpu_a = set_nz(cpu_a | w.operand);
      OP_EOR: cpu_a = set_nz(cpu_a ^ w.operand);
      OP_CMP: compare_reg(cpu_a, w.operand);
      OP_CPX: compare_reg(cpu_x, w.operand);
      OP_CPY: compare_reg(cpu_y, w.operand);
      OP_BIT: begin
        flag_n = w.operand[7];
        flag_v = w.operand[6];
        flag_z = ((cpu_a & w.operand) == 8'h00);
      end
      OP_ASL, OP_ROL, OP_ROR, OP_INC, OP_DEC: begin
        if (w.to_acc) begin
          cpu_a = shift_or_step(w.kind, cpu_a);
        end else begin
          r.result_byte  = shift_or_step(w.kind, w.operand);
          r.write_memory = 1'b1;
        end
      end
      OP_LDA: cpu_a = set_nz(w.operand);
      OP_LDX: cpu_x = set_nz(w.operand);
      OP_LDY: cpu_y = set_nz(w.operand);
      OP_STA: begin
        r.result_byte  = cpu_a;
        r.write_memory = 1'b1;
      end
      OP_STX: begin
        r.result_byte  = cpu_x;
        r.write_memory = 1'b1;
      end
      OP_STY: begin
        r.result_byte  = cpu_y;
        r.write_memory = 1'b1;
      end
      OP_TAX: cpu_x = set_nz(cpu_a);
      OP_TAY: cpu_y = set_nz(cpu_a);
      OP_TXA: cpu_a = set_nz(cpu_x);
      OP_TYA: cpu_a = set_nz(cpu_y);
      OP_TSX: cpu_x = set_nz(cpu_sp);
      OP_TXS: cpu_sp = cpu_x;
      OP_INX: cpu_x = set_nz(cpu_x + 8'h01);
      OP_INY: cpu_y = set_nz(cpu_y + 8'h01);
      OP_DEX: cpu_x = set_nz(cpu_x - 8'h01);
      OP_DEY: cpu_y = set_nz(cpu_y - 8'h01);
      OP_CLC: flag_c = 1'b0;
      OP_SEC: flag_c = 1'b1;
      OP_CLI: flag_i = 1'b0;
      OP_SEI: flag_i = 1'b1;
      OP_CLD: flag_d = 1'b0;
      OP_SED: flag_d = 1'b1;
      OP_CLV: flag_v = 1'b0;
      OP_BRANCH: begin
        if (branch_holds(w.cond)) begin
          r.branch_taken = 1'b1;
          r.next_pc      = w.pc + {{8{w.operand[7]}}, w.operand};
        end
      end
      default: ;
    endcase
    r.status_flags = {flag_n, flag_v, 1'b1, 1'b0, flag_d, flag_i, flag_z, flag_c};
    return r;
  endfunction

  function automatic instr_t random_instr();
    instr_t w;
    w.kind    = ($urandom_range(0, 99) < 92) ? KindW'($urandom_range(0, OP_NOP))
                                             : KindW'($urandom_range(OP_NOP + 1, KindTop));
    w.operand = ($urandom_range(0, 3) == 0) ? BoundaryBytes[3'($urandom_range(0, 4))]
                                            : ByteW'($urandom);
    w.to_acc  = 1'($urandom_range(0, 1));
    w.cond    = CondW'($urandom_range(0, 7));
    w.pc      = ($urandom_range(0, 7) == 0) ? PcW'($urandom_range(16'hFF80, 16'hFFFF))
                                            : PcW'($urandom);
    return w;
  endfunction

  // Offer one word, hold it until taken, then record the expectation
  task automatic send_word(input instr_t w, input logic typed, input result_t typed_res);
    int      gap;
    result_t predicted;
    gap = quiet_in ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(InDataW - 34){1'b0}}, w.pc, w.cond, w.to_acc, w.operand, w.kind};
    do @(posedge clk); while (!in_tready);
    predicted = execute_instr(w);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic drain_pending();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      error_count++;
      if (error_count <= MaxReports)
        $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, name, want, got);
    end
  endtask

  initial begin : result_sink
    int      stall;
    int      seen;
    result_t got;
    result_t want;
    seen = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = quiet_out ? 0 : $urandom_range(0, MaxGap);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got.result_byte  = out_tdata[7:0];
      got.write_memory = out_tdata[8];
      got.status_flags = out_tdata[16:9];
      got.branch_taken = out_tdata[17];
      got.next_pc      = out_tdata[33:18];
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MaxReports)
          $display("%0t: unexpected word 0x%0h", $realtime, out_tdata);
      end else begin
        want = pending_results.pop_front();
        check_field("result_byte", want.result_byte, got.result_byte);
        check_field("write_memory", want.write_memory, got.write_memory);
        check_field("status_flags", want.status_flags, got.status_flags);
        check_field("branch_taken", want.branch_taken, got.branch_taken);
        check_field("next_pc", want.next_pc, got.next_pc);
      end
      seen++;
      if (seen % 64 == 0) quiet_out = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin : stimulus
    int      i;
    int      guard;
    result_t none;
    none   = '0;
    cpu_a  = 8'h00;
    cpu_x  = 8'h00;
    cpu_y  = 8'h00;
    cpu_sp = SpReset;
    {flag_c, flag_z, flag_d, flag_v, flag_n} = '0;
    flag_i = 1'b1;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DirectedRows; i++)
      send_word(directed_rows[i].insn, directed_rows[i].typed, directed_rows[i].want);
    drain_pending();

    for (i = 0; i < RandomWords; i++) begin
      if (i % 64 == 0) quiet_in = ($urandom_range(0, 3) == 0);
      if (i == RandomWords / 2) drain_pending();
      send_word(random_instr(), 1'b0, none);
    end
    in_tvalid <= 1'b0;

    guard = 0;
    while (pending_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_results.size() != 0) error_count++;
    repeat (10) @(posedge clk);

    if (error_count == 0) begin
      $display("tb_byte_cpu_execute_unit: clean");
    end else begin
      $display("tb_byte_cpu_execute_unit: errors");
    end
    $finish;
  end

endmodule
